// File: design/ptsr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tilt servo ramp package
// Shared types, register indexes and reset values for the tilt servo ramp.
// ---------------------------------------------------------------------------
package ptsr_pkg;

  localparam int PERIOD_W = 26;
  localparam int STEP_W   = 16;
  localparam int ANGLE_W  = 8;
  localparam int CFG_W    = 26;
  localparam int INDEX_W  = 2;

  // Configuration register indexes.
  localparam logic [INDEX_W-1:0] REG_TURN_PERIOD   = 2'd0;
  localparam logic [INDEX_W-1:0] REG_STEP_INTERVAL = 2'd1;
  localparam logic [INDEX_W-1:0] REG_UP_ANGLE      = 2'd2;
  localparam logic [INDEX_W-1:0] REG_DOWN_ANGLE    = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [PERIOD_W-1:0] TURN_PERIOD_RST   = 26'd10800000;
  localparam logic [STEP_W-1:0]   STEP_INTERVAL_RST = 16'd20;
  localparam logic [ANGLE_W-1:0]  UP_ANGLE_RST      = 8'd15;
  localparam logic [ANGLE_W-1:0]  DOWN_ANGLE_RST    = 8'd165;

  typedef struct packed {
    logic [PERIOD_W-1:0] turn_period;
    logic [STEP_W-1:0]   step_interval;
    logic [ANGLE_W-1:0]  up_angle;
    logic [ANGLE_W-1:0]  down_angle;
  } cfg_t;

  typedef struct packed {
    logic               at_target;
    logic               tilted_up;
    logic [ANGLE_W-1:0] servo_angle;
  } result_t;

endpackage

// File: design/periodic_tilt_servo_ramp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Periodic tilt servo ramp
// Tilt reversal timer with a rate-limited one-degree servo ramp.
// ---------------------------------------------------------------------------
// Usage:
//   Each beat on the slave stream is one millisecond tick; s_tdata bit 0 is
//   the qualified button press. Every tick yields exactly one beat on the
//   master stream with the servo angle, the tilt direction and whether the
//   servo sits on its target.
//   Configuration is written through cfg_wr_en / cfg_index / cfg_data; the
//   user must write it only while no tick is in flight, which the block does
//   not enforce. A write takes effect at its clock edge. The result beat is
//   registered and appears in the cycle after its tick is accepted. The tick
//   state update and the result are computed in one pass, so the rate is one
//   tick per cycle while the receiver takes beats. While the receiver stalls,
//   the result register holds its beat and s_tready stays low until that beat
//   is taken; a beat taken in the same cycle lets a new tick in.
//   Synchronous reset restores the default configuration, sets the servo
//   position and target to zero with the tilt down, clears both timers,
//   and empties the result register.
// ---------------------------------------------------------------------------
module periodic_tilt_servo_ramp import ptsr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [0] button_press, [7:1] zero
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata,   // [7:0] servo_angle, [8] tilted_up,
                                        // [9] at_target, [15:10] zero
  input  logic               cfg_wr_en,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  cfg_t    cfg;
  result_t result;
  logic    tick;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.turn_period   <= TURN_PERIOD_RST;
      cfg.step_interval <= STEP_INTERVAL_RST;
      cfg.up_angle      <= UP_ANGLE_RST;
      cfg.down_angle    <= DOWN_ANGLE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TURN_PERIOD:   cfg.turn_period   <= cfg_data;
        REG_STEP_INTERVAL: cfg.step_interval <= cfg_data[STEP_W-1:0];
        REG_UP_ANGLE:      cfg.up_angle      <= cfg_data[ANGLE_W-1:0];
        REG_DOWN_ANGLE:    cfg.down_angle    <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // A tick enters when the result register is empty or being drained.
  assign s_tready = !m_tvalid || m_tready;
  assign tick     = s_tvalid && s_tready;

  ptsr_core u_core (
    .clk          (clk),
    .rst          (rst),
    .tick         (tick),
    .button_press (s_tdata[0]),
    .cfg          (cfg),
    .result       (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      m_tdata <= {6'd0, result.at_target, result.tilted_up, result.servo_angle};
    end
  end

endmodule

// File: design/ptsr_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tilt servo ramp core
// Holds the tilt and ramp state and works out one tick in a single pass.
// ---------------------------------------------------------------------------
module ptsr_core import ptsr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    tick,
  input  logic    button_press,
  input  cfg_t    cfg,
  output result_t result
);

  logic [ANGLE_W-1:0]  position, position_next;
  logic [ANGLE_W-1:0]  target, target_next;
  logic                tilt_up, tilt_up_next;
  logic [PERIOD_W-1:0] period_elapsed, period_elapsed_next;
  logic [STEP_W-1:0]   step_elapsed, step_elapsed_next;
  logic                step_forced, step_forced_next;

  logic [PERIOD_W-1:0] period_inc;
  logic [STEP_W-1:0]   step_inc;
  logic                period_due;
  logic                tilt_mid;
  logic [ANGLE_W-1:0]  target_mid;
  logic                step_now;

  always_comb begin
    // Saturating tick counters.
    period_inc = (period_elapsed != '1) ? period_elapsed + 1'b1 : period_elapsed;
    step_inc   = (step_elapsed != '1) ? step_elapsed + 1'b1 : step_elapsed;

    // Automatic reversal when the period has been exceeded.
    period_due = period_inc > cfg.turn_period;
    tilt_mid   = period_due ? ~tilt_up : tilt_up;
    target_mid = period_due ? (tilt_up ? cfg.down_angle : cfg.up_angle) : target;

    // One-degree ramp step toward the target in force after the period check.
    step_now = (position != target_mid) &&
               (step_forced || (step_inc > cfg.step_interval));
    position_next     = position;
    step_elapsed_next = step_inc;
    step_forced_next  = step_forced;
    if (step_now) begin
      position_next     = (position < target_mid) ? position + 1'b1 : position - 1'b1;
      step_elapsed_next = '0;
      step_forced_next  = 1'b0;
    end

    // A press reverses again, forces a step and restarts the period.
    period_elapsed_next = period_due ? '0 : period_inc;
    tilt_up_next        = tilt_mid;
    target_next         = target_mid;
    if (button_press) begin
      tilt_up_next        = ~tilt_mid;
      target_next         = tilt_mid ? cfg.down_angle : cfg.up_angle;
      step_forced_next    = 1'b1;
      period_elapsed_next = '0;
    end

    result.servo_angle = position_next;
    result.tilted_up   = tilt_up_next;
    result.at_target   = position_next == target_next;
  end

  // State registers, updated on every accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      target         <= '0;
      tilt_up        <= 1'b0;
      period_elapsed <= '0;
      step_elapsed   <= '0;
      step_forced    <= 1'b0;
    end else if (tick) begin
      position       <= position_next;
      target         <= target_next;
      tilt_up        <= tilt_up_next;
      period_elapsed <= period_elapsed_next;
      step_elapsed   <= step_elapsed_next;
      step_forced    <= step_forced_next;
    end
  end

endmodule
